FILE: hw/rtl/mt_pkg.sv
// shared constants, types and command codes of the mersenne twister generator
package mt_pkg;

  // state array geometry
  localparam int unsigned WORDS     = 624;
  localparam int unsigned SHIFT_POS = 397;
  localparam int unsigned ADDR_W    = 10;

  // key store geometry
  localparam int unsigned KEY_DEPTH = 16;
  localparam int unsigned KEY_IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KEY_CNT_W = $clog2(KEY_DEPTH + 1);

  // payload and register widths
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned KEY_INDEX_W = 4;
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef logic [31:0] mt_word_t;

  // algorithm constants
  localparam mt_word_t MAT_A        = 32'h9908b0df;
  localparam mt_word_t HI_MASK      = 32'h80000000;
  localparam mt_word_t LO_MASK      = 32'h7fffffff;
  localparam mt_word_t SEED_MULT    = 32'd1812433253;
  localparam mt_word_t ARR_MULT_A   = 32'd1664525;
  localparam mt_word_t ARR_MULT_B   = 32'd1566083941;
  localparam mt_word_t ARRAY_SEED   = 32'd19650218;
  localparam mt_word_t DEFAULT_SEED = 32'd5489;
  localparam mt_word_t TEMPER_B     = 32'h9d2c5680;
  localparam mt_word_t TEMPER_C     = 32'hefc60000;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
  localparam logic [ADDR_W-1:0] WORDS_A   = ADDR_W'(WORDS);

  // input modes
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ARRAY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 1'd1;

  localparam mt_word_t              SEED_RESET    = 32'd5489;
  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET = 5'd1;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_DR_ACC,
    OP_SEED_INIT,
    OP_SEED_MUL,
    OP_SEED_WR,
    OP_ARR_INIT,
    OP_ARR_RD,
    OP_ARR_WR,
    OP_ARR_WRAP,
    OP_ARR_B_INIT,
    OP_ARR_FINAL,
    OP_TW_PRIME,
    OP_TW_RD,
    OP_TW_WR,
    OP_DR_RD,
    OP_DR_OUT
  } mt_op_e;

  // source of the single-word seed
  typedef enum logic [1:0] {
    SEL_CFG,
    SEL_DEFAULT,
    SEL_ARRAY
  } mt_seed_sel_e;

  typedef struct packed {
    mt_op_e       op;
    mt_seed_sel_e seed_sel;
    logic         phase_b;
  } mt_cmd_t;

  typedef struct packed {
    logic wr_one;
    logic seeded;
    logic i_last;
    logic k_one;
    logic k_zero;
    logic out_free;
  } mt_sts_t;

endpackage

FILE: hw/rtl/mt_ifs.sv
// valid/ready stream interfaces for the request and result channels

interface mt_in_if;
  logic                            valid;
  logic                            ready;
  logic [mt_pkg::MODE_W-1:0]      mode;
  logic [mt_pkg::KEY_INDEX_W-1:0] key_index;
  mt_pkg::mt_word_t               key_word;

  modport source (output valid, mode, key_index, key_word, input ready);
  modport sink   (input valid, mode, key_index, key_word, output ready);
endinterface

interface mt_out_if;
  logic             valid;
  logic             ready;
  mt_pkg::mt_word_t number;

  modport source (output valid, number, input ready);
  modport sink   (input valid, number, output ready);
endinterface

FILE: hw/rtl/mersenne_twister_generator.sv
// top level of the 32-bit mersenne twister generator
// A draw (mode 0) is accepted, reads the state memory and is tempered into the output
// register, where tempering waits until a previous result is taken. Every 624th draw, and
// the first after a seeding item, first refills the state with the twist, reading and then
// writing each word, paced by the single write port of the 624-word state memory. Seeding
// from the seed register (mode 1) takes each word through the registered 32x32 multiplier
// and then writes it; array seeding (mode 3) runs that pass and then two more passes, a
// key pass and a mixing pass. A draw that comes before any seeding adds one single-word
// seeding pass with the value 5489. A key word write (mode 2) is stored as it is accepted.
// No new request is taken while a pass runs; a finished result waits in the output
// register while the next request is accepted. There is no clearing pass after reset.
module mersenne_twister_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mt_in_if.sink                          in_i,
  mt_out_if.source                       out_o,
  input  logic                           cfg_we_i,
  input  logic [mt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mt_pkg::*;

  mt_cmd_t cmd;
  mt_sts_t sts;
  logic    in_ready;

  assign in_i.ready = in_ready;

  // sequencing
  mt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // storage and arithmetic
  mt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .key_index_i  (in_i.key_index),
    .key_word_i   (in_i.key_word),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_o.valid),
    .out_number_o (out_o.number),
    .out_ready_i  (out_o.ready)
  );

endmodule

FILE: hw/rtl/mt_dp.sv
// datapath: state memory, key store, shared multiplier, counters and output register
module mt_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mt_pkg::mt_cmd_t                 cmd_i,
  output mt_pkg::mt_sts_t                 sts_o,
  input  logic [mt_pkg::KEY_INDEX_W-1:0] key_index_i,
  input  mt_pkg::mt_word_t                key_word_i,
  input  logic                            cfg_we_i,
  input  logic [mt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            out_valid_o,
  output mt_pkg::mt_word_t                out_number_o,
  input  logic                            out_ready_i
);
  import mt_pkg::*;

  // state memory with two registered read ports
  mt_word_t          mem [WORDS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  mt_word_t          mem_wdata;
  logic              rd_a_en, rd_b_en;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  mt_word_t          rd_a_q, rd_b_q;

  // key store
  mt_word_t             key_q [KEY_DEPTH];
  logic                 key_we;
  logic [KEY_IDX_W-1:0] key_waddr;
  mt_word_t             key_rd_q;

  // working registers
  logic [ADDR_W-1:0]    i_q, i_d, k_q, k_d, rp_q, rp_d, wr_q, wr_d;
  logic [KEY_IDX_W-1:0] j_q, j_d;
  logic [KEY_CNT_W-1:0] len_q, len_d;
  mt_word_t             p_q, p_d, prod_q, prod_d, cur_q, cur_d, out_num_q, out_num_d;
  logic                 first_q, first_d, seeded_q, seeded_d, out_valid_q, out_valid_d;

  // configuration registers
  mt_word_t             seed_cfg_q;
  logic [KEY_LEN_W-1:0] key_len_cfg_q;

  // intermediate values
  mt_word_t          mix, mult_const, seed_val, ar_mix, ar_val_a, ar_val_b, tw_y, tw_val;
  logic [63:0]       mul_full;
  logic [ADDR_W-1:0] i_inc, nxt_addr, far_addr, dr_addr;
  logic [ADDR_W:0]   far_sum;
  logic [31:0]       j_inc, len_lim;
  logic              j_wrap, key_ok;

  // output tempering
  function automatic mt_word_t temper(input mt_word_t v);
    mt_word_t y;
    y = v;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // shared multiplier, low word only
  always_comb begin
    mix = p_q ^ (p_q >> 30);
    if (cmd_i.op == OP_SEED_MUL) begin
      mult_const = SEED_MULT;
    end else if (cmd_i.phase_b) begin
      mult_const = ARR_MULT_B;
    end else begin
      mult_const = ARR_MULT_A;
    end
    mul_full = {32'd0, mix} * {32'd0, mult_const};
  end

  // address arithmetic and step values
  always_comb begin
    i_inc    = i_q + 1'b1;
    nxt_addr = (i_q == LAST_ADDR) ? '0 : i_inc;
    far_sum  = {1'b0, i_q} + (ADDR_W + 1)'(SHIFT_POS);
    far_addr = (far_sum >= (ADDR_W + 1)'(WORDS)) ? ADDR_W'(far_sum - (ADDR_W + 1)'(WORDS))
                                                 : ADDR_W'(far_sum);
    dr_addr  = (rp_q >= WORDS_A) ? '0 : rp_q;
    ar_mix   = rd_a_q ^ prod_q;
    ar_val_a = ar_mix + key_rd_q + 32'(j_q);
    ar_val_b = ar_mix - 32'(i_q);
    tw_y     = (cur_q & HI_MASK) | (rd_a_q & LO_MASK);
    tw_val   = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? MAT_A : 32'd0);
    j_inc    = 32'(j_q) + 32'd1;
    j_wrap   = j_inc >= 32'(len_q);
    key_ok   = 32'(key_index_i) < KEY_DEPTH;
    // zero length reads as one, long lengths saturate at the store depth
    len_lim  = (key_len_cfg_q == '0) ? 32'd1 : 32'(key_len_cfg_q);
    if (len_lim > KEY_DEPTH) begin
      len_lim = KEY_DEPTH;
    end
    case (cmd_i.seed_sel)
      SEL_CFG:     seed_val = seed_cfg_q;
      SEL_DEFAULT: seed_val = DEFAULT_SEED;
      default:     seed_val = ARRAY_SEED;
    endcase
  end

  // operation decode
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = p_q;
    rd_a_en     = 1'b0;
    rd_a_addr   = i_q;
    rd_b_en     = 1'b0;
    rd_b_addr   = far_addr;
    key_we      = 1'b0;
    key_waddr   = KEY_IDX_W'(key_index_i);
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    len_d       = len_q;
    p_d         = p_q;
    prod_d      = prod_q;
    cur_d       = cur_q;
    first_d     = first_q;
    rp_d        = rp_q;
    wr_d        = wr_q;
    seeded_d    = seeded_q;
    out_num_d   = out_num_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_KEY_WR: begin
        key_we = key_ok;
      end
      OP_DR_ACC: begin
        wr_d = wr_q - 1'b1;
      end
      OP_SEED_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = seed_val;
        p_d       = seed_val;
        i_d       = ADDR_W'(1);
      end
      OP_SEED_MUL: begin
        prod_d = mul_full[31:0];
      end
      OP_SEED_WR: begin
        mem_we    = 1'b1;
        mem_wdata = prod_q + 32'(i_q);
        p_d       = prod_q + 32'(i_q);
        i_d       = i_inc;
        if (i_q == LAST_ADDR) begin
          wr_d     = ADDR_W'(1);
          seeded_d = 1'b1;
        end
      end
      OP_ARR_INIT: begin
        // the first pass always runs the full word count since keys are shorter
        i_d   = ADDR_W'(1);
        j_d   = '0;
        k_d   = WORDS_A;
        p_d   = ARRAY_SEED;
        len_d = KEY_CNT_W'(len_lim);
      end
      OP_ARR_RD: begin
        rd_a_en = 1'b1;
        prod_d  = mul_full[31:0];
      end
      OP_ARR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = cmd_i.phase_b ? ar_val_b : ar_val_a;
        p_d       = cmd_i.phase_b ? ar_val_b : ar_val_a;
        k_d       = k_q - 1'b1;
        if (i_q != LAST_ADDR) begin
          i_d = i_inc;
        end
        if (!cmd_i.phase_b) begin
          j_d = j_wrap ? '0 : KEY_IDX_W'(j_inc);
        end
      end
      OP_ARR_WRAP: begin
        // word zero takes a copy of the last word
        mem_we    = 1'b1;
        mem_waddr = '0;
        i_d       = ADDR_W'(1);
      end
      OP_ARR_B_INIT: begin
        k_d = LAST_ADDR;
      end
      OP_ARR_FINAL: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = HI_MASK;
        wr_d      = ADDR_W'(1);
        seeded_d  = 1'b1;
      end
      OP_TW_PRIME: begin
        rd_a_en   = 1'b1;
        rd_a_addr = '0;
        i_d       = '0;
        first_d   = 1'b1;
      end
      OP_TW_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = nxt_addr;
        rd_b_en   = 1'b1;
        if (first_q) begin
          cur_d   = rd_a_q;
          first_d = 1'b0;
        end
      end
      OP_TW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = tw_val;
        cur_d     = rd_a_q;
        if (i_q == LAST_ADDR) begin
          wr_d = WORDS_A;
          rp_d = '0;
        end else begin
          i_d = i_inc;
        end
      end
      OP_DR_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = dr_addr;
        rp_d      = dr_addr + 1'b1;
      end
      OP_DR_OUT: begin
        out_num_d   = temper(rd_a_q);
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status back to the controller
  always_comb begin
    sts_o.wr_one   = (wr_q == ADDR_W'(1));
    sts_o.seeded   = seeded_q;
    sts_o.i_last   = (i_q == LAST_ADDR);
    sts_o.k_one    = (k_q == ADDR_W'(1));
    sts_o.k_zero   = (k_q == '0);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_number_o = out_num_q;

  // state memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // state memory read ports
  always_ff @(posedge clk_i) begin
    if (rd_a_en) begin
      rd_a_q <= mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_b_en) begin
      rd_b_q <= mem[rd_b_addr];
    end
  end

  // key store write
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[key_waddr] <= key_word_i;
    end
  end

  // key store read, alongside each state word read of the array passes; only the key pass uses it
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ARR_RD) begin
      key_rd_q <= key_q[j_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    p_q       <= p_d;
    prod_q    <= prod_d;
    cur_q     <= cur_d;
    out_num_q <= out_num_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rp_q        <= '0;
      wr_q        <= ADDR_W'(1);
      first_q     <= 1'b0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rp_q        <= rp_d;
      wr_q        <= wr_d;
      first_q     <= first_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_cfg_q    <= SEED_RESET;
      key_len_cfg_q <= KEY_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED:    seed_cfg_q    <= cfg_data_i;
        CFG_KEY_LEN: key_len_cfg_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/mt_ctrl.sv
// controller: sequences draws, key writes, seeding passes and the twist refill
module mt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [mt_pkg::MODE_W-1:0] in_mode_i,
  output logic                       in_ready_o,
  output mt_pkg::mt_cmd_t            cmd_o,
  input  mt_pkg::mt_sts_t            sts_i
);
  import mt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SW_INIT  = 4'd1;
  localparam logic [3:0] S_SW_MUL   = 4'd2;
  localparam logic [3:0] S_SW_WR    = 4'd3;
  localparam logic [3:0] S_AR_INIT  = 4'd4;
  localparam logic [3:0] S_AR_RD    = 4'd5;
  localparam logic [3:0] S_AR_WR    = 4'd6;
  localparam logic [3:0] S_AR_WRAP  = 4'd7;
  localparam logic [3:0] S_AR_BINIT = 4'd8;
  localparam logic [3:0] S_AR_FINAL = 4'd9;
  localparam logic [3:0] S_TW_PRIME = 4'd10;
  localparam logic [3:0] S_TW_RD    = 4'd11;
  localparam logic [3:0] S_TW_WR    = 4'd12;
  localparam logic [3:0] S_DR_RD    = 4'd13;
  localparam logic [3:0] S_DR_OUT   = 4'd14;

  // what follows the single-word seeding pass
  localparam logic [1:0] JOB_DRAW  = 2'd0;
  localparam logic [1:0] JOB_SEED  = 2'd1;
  localparam logic [1:0] JOB_ARRAY = 2'd2;

  logic [3:0]   state_q, state_d;
  logic [1:0]   job_q, job_d;
  mt_seed_sel_e sel_q, sel_d;
  logic         phase_q, phase_d;
  logic         in_xfer;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // next state and command
  always_comb begin
    state_d        = state_q;
    job_d          = job_q;
    sel_d          = sel_q;
    phase_d        = phase_q;
    cmd_o.op       = OP_NONE;
    cmd_o.seed_sel = sel_q;
    cmd_o.phase_b  = phase_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_mode_i)
            MODE_DRAW: begin
              cmd_o.op = OP_DR_ACC;
              if (!sts_i.wr_one) begin
                state_d = S_DR_RD;
              end else if (sts_i.seeded) begin
                state_d = S_TW_PRIME;
              end else begin
                job_d   = JOB_DRAW;
                sel_d   = SEL_DEFAULT;
                state_d = S_SW_INIT;
              end
            end
            MODE_SEED: begin
              job_d   = JOB_SEED;
              sel_d   = SEL_CFG;
              state_d = S_SW_INIT;
            end
            MODE_KEY: begin
              cmd_o.op = OP_KEY_WR;
            end
            MODE_ARRAY: begin
              job_d   = JOB_ARRAY;
              sel_d   = SEL_ARRAY;
              state_d = S_SW_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      // single-word seeding
      S_SW_INIT: begin
        cmd_o.op = OP_SEED_INIT;
        state_d  = S_SW_MUL;
      end
      S_SW_MUL: begin
        cmd_o.op = OP_SEED_MUL;
        state_d  = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.op = OP_SEED_WR;
        if (!sts_i.i_last) begin
          state_d = S_SW_MUL;
        end else if (job_q == JOB_ARRAY) begin
          state_d = S_AR_INIT;
        end else if (job_q == JOB_DRAW) begin
          state_d = S_TW_PRIME;
        end else begin
          state_d = S_IDLE;
        end
      end
      // array seeding, key pass then mixing pass
      S_AR_INIT: begin
        cmd_o.op = OP_ARR_INIT;
        phase_d  = 1'b0;
        state_d  = S_AR_RD;
      end
      S_AR_RD: begin
        cmd_o.op = OP_ARR_RD;
        state_d  = S_AR_WR;
      end
      S_AR_WR: begin
        cmd_o.op = OP_ARR_WR;
        if (sts_i.i_last) begin
          state_d = S_AR_WRAP;
        end else if (sts_i.k_one) begin
          state_d = phase_q ? S_AR_FINAL : S_AR_BINIT;
        end else begin
          state_d = S_AR_RD;
        end
      end
      S_AR_WRAP: begin
        cmd_o.op = OP_ARR_WRAP;
        if (sts_i.k_zero) begin
          state_d = phase_q ? S_AR_FINAL : S_AR_BINIT;
        end else begin
          state_d = S_AR_RD;
        end
      end
      S_AR_BINIT: begin
        cmd_o.op = OP_ARR_B_INIT;
        phase_d  = 1'b1;
        state_d  = S_AR_RD;
      end
      S_AR_FINAL: begin
        cmd_o.op = OP_ARR_FINAL;
        state_d  = S_IDLE;
      end
      // twist refill
      S_TW_PRIME: begin
        cmd_o.op = OP_TW_PRIME;
        state_d  = S_TW_RD;
      end
      S_TW_RD: begin
        cmd_o.op = OP_TW_RD;
        state_d  = S_TW_WR;
      end
      S_TW_WR: begin
        cmd_o.op = OP_TW_WR;
        state_d  = sts_i.i_last ? S_DR_RD : S_TW_RD;
      end
      // draw
      S_DR_RD: begin
        cmd_o.op = OP_DR_RD;
        state_d  = S_DR_OUT;
      end
      S_DR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_DR_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= JOB_DRAW;
      sel_q   <= SEL_CFG;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      sel_q   <= sel_d;
      phase_q <= phase_d;
    end
  end

endmodule
